>>> rtl/ifsc_pkg.sv
// shared constants and types for the increasing five-subsequence counter
package ifsc_pkg;

   localparam int MAX_RANK = 4096;
   localparam int RANK_W   = 13;
   localparam int ADDR_W   = $clog2(MAX_RANK);
   localparam int POS_W    = ADDR_W + 2;
   localparam int W1       = 13;
   localparam int W2       = 24;
   localparam int W3       = 34;
   localparam int W4       = 44;
   localparam int TOTAL_W  = 54;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total_count;
      logic               last_out;
   } rsp_type;

   // classified item handed from the front to the back
   typedef struct packed {
      logic             in_range;
      logic [POS_W-1:0] pos;
      logic             last;
   } item_type;

   // one row of the four trees, read and written together
   typedef struct packed {
      logic [W4-1:0] len_four;
      logic [W3-1:0] len_three;
      logic [W2-1:0] len_two;
      logic [W1-1:0] len_one;
   } tree_word_type;

endpackage

>>> rtl/increasing_five_subsequence_counter_top.sv
// top level of the increasing five-subsequence counter
//
//   channel   direction  transfer when       payload
//   request   in         push & !full        req_data  (rank, last)
//   response  out        pop & !empty        rsp_data  (total_count, last_out)
//
// an item in range is taken, then the query reads popcount(rank-1) tree rows (none when
// rank is 1), the update reads and writes back each row on its path and the result is
// pushed; query reads plus update path length is always 13 at 4096 ranks, and all reads
// and writes go through the one memory port pair over the four trees
// an out-of-range item goes from its take straight to its result, with the total unchanged
// after reset and after each last item the tree memory is zeroed one row a cycle,
// and no item is taken while that runs
// a full response queue holds the sequencer in its result state
module increasing_five_subsequence_counter_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ifsc_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output ifsc_pkg::rsp_type rsp_data
);
   import ifsc_pkg::*;

   logic     item_valid;
   logic     item_take;
   item_type item;
   logic     rsp_full;
   logic     rsp_push;
   rsp_type  rsp_out;

   ifsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   ifsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_out    (rsp_out)
   );

   ifsc_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_in   (rsp_out),
      .rsp_full (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

>>> rtl/ifsc_front.sv
// input queue that range-checks each element before the tree sequencer
module ifsc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ifsc_pkg::req_type req_data,
   output logic              item_valid,
   input  logic              item_take,
   output ifsc_pkg::item_type item
);
   import ifsc_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   cls;
   logic       do_wr, do_rd;

   always_comb begin
      cls.in_range = (req_data.rank != '0) && (32'(req_data.rank) <= MAX_RANK);
      cls.pos      = POS_W'(req_data.rank);
      cls.last     = req_data.last;
   end

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];
   assign do_wr      = push && !full;
   assign do_rd      = item_take && item_valid;

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

>>> rtl/ifsc_rsp_queue.sv
// two-entry result queue toward the consumer
module ifsc_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_push,
   input  ifsc_pkg::rsp_type rsp_in,
   output logic              rsp_full,
   output logic              empty,
   input  logic              pop,
   output ifsc_pkg::rsp_type rsp_data
);
   import ifsc_pkg::*;

   rsp_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign rsp_full = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rsp_data = q_ff[rd_ptr_ff];
   assign do_wr    = rsp_push && !rsp_full;
   assign do_rd    = pop && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

>>> rtl/ifsc_back.sv
// fenwick query and update sequencer over the shared four-tree memory
module ifsc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  ifsc_pkg::item_type item,
   output logic               item_take,
   input  logic               rsp_full,
   output logic               rsp_push,
   output ifsc_pkg::rsp_type  rsp_out
);
   import ifsc_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_QUERY  = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   tree_word_type mem [MAX_RANK];
   tree_word_type rd_data_ff;

   logic [2:0]         state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   rank_ff, rank_in;
   logic               last_ff, last_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic               rdv_ff, rdv_in;
   logic [ADDR_W-1:0]  wa_ff, wa_in;
   logic [W1-1:0]      acc1_ff, acc1_in;
   logic [W2-1:0]      acc2_ff, acc2_in;
   logic [W3-1:0]      acc3_ff, acc3_in;
   logic [W4-1:0]      acc4_ff, acc4_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic [POS_W-1:0]  pos_dec, pos_low;
   logic              in_tree;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic              wr_en;
   tree_word_type     wr_data, upd_word;

   assign pos_dec = pos_ff - POS_W'(1);
   assign pos_low = pos_ff & (~pos_ff + POS_W'(1));
   assign in_tree = (32'(pos_ff) <= MAX_RANK);
   assign rd_addr = pos_dec[ADDR_W-1:0];

   // each tree entry on the update path gains the count one length shorter
   always_comb begin
      upd_word.len_one   = rd_data_ff.len_one + W1'(1);
      upd_word.len_two   = rd_data_ff.len_two + W2'(acc1_ff);
      upd_word.len_three = rd_data_ff.len_three + W3'(acc2_ff);
      upd_word.len_four  = rd_data_ff.len_four + W4'(acc3_ff);
   end

   assign rsp_out.total_count = total_ff;
   assign rsp_out.last_out    = last_ff;

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      rank_in   = rank_ff;
      last_in   = last_ff;
      clr_in    = clr_ff;
      rdv_in    = 1'b0;
      wa_in     = wa_ff;
      acc1_in   = acc1_ff;
      acc2_in   = acc2_ff;
      acc3_in   = acc3_ff;
      acc4_in   = acc4_ff;
      total_in  = total_ff;
      wr_en     = 1'b0;
      wr_addr   = wa_ff;
      wr_data   = upd_word;
      item_take = 1'b0;
      rsp_push  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MAX_RANK - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               rank_in   = item.pos;
               pos_in    = item.pos - POS_W'(1);
               last_in   = item.last;
               acc1_in   = '0;
               acc2_in   = '0;
               acc3_in   = '0;
               acc4_in   = '0;
               state_in  = item.in_range ? ST_QUERY : ST_FINISH;
            end
         end
         ST_QUERY: begin
            // read data is registered and arrives in the cycle after its address
            if (rdv_ff) begin
               acc1_in = acc1_ff + rd_data_ff.len_one;
               acc2_in = acc2_ff + rd_data_ff.len_two;
               acc3_in = acc3_ff + rd_data_ff.len_three;
               acc4_in = acc4_ff + rd_data_ff.len_four;
            end
            if (pos_ff != '0) begin
               pos_in = pos_ff & pos_dec;
               rdv_in = 1'b1;
            end else if (!rdv_ff) begin
               pos_in   = rank_ff;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // write back the entry read last cycle while reading the next one
            if (rdv_ff) begin
               wr_en = 1'b1;
            end
            if (in_tree) begin
               wa_in  = rd_addr;
               pos_in = pos_ff + pos_low;
               rdv_in = 1'b1;
            end else if (!rdv_ff) begin
               total_in = total_ff + TOTAL_W'(acc4_ff);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (last_ff) begin
                  clr_in   = '0;
                  total_in = '0;
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         rdv_ff   <= 1'b0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rdv_ff   <= rdv_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      rank_ff <= rank_in;
      last_ff <= last_in;
      wa_ff   <= wa_in;
      acc1_ff <= acc1_in;
      acc2_ff <= acc2_in;
      acc3_ff <= acc3_in;
      acc4_ff <= acc4_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_query_read_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QUERY) |-> !wr_en)
      else $error("tree written during prefix query");

   a_update_no_collision: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && rdv_ff && in_tree) |-> (wr_addr != rd_addr))
      else $error("update read and write hit the same row");

   a_take_starts_work: assert property (@(posedge clock) disable iff (reset)
      item_take |=> (state_ff == ST_QUERY || state_ff == ST_FINISH))
      else $error("taken item did not start work");

   a_clear_total_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (total_ff == '0))
      else $error("total not zero while clearing");
`endif

endmodule
